FILE: hdl/instruction_prefetch_align_buffer_top_assert.svh
// Assertion macros used by the alignment buffer datapath.
`ifndef INSTRUCTION_PREFETCH_ALIGN_BUFFER_TOP_ASSERT_SVH
`define INSTRUCTION_PREFETCH_ALIGN_BUFFER_TOP_ASSERT_SVH

// Clocked assertion that is disabled while reset is high.
`define IPAB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define IPAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ipab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipab_pkg;

   localparam int WINDOW_BITS      = 64;
   localparam int WORD_BITS        = 16;
   localparam int WORDS_PER_WINDOW = 4;
   localparam int ADDR_BITS        = 16;
   localparam int CODE_BITS        = 5;
   localparam int COUNT_BITS       = 4;
   localparam int ACTION_BITS      = 3;
   localparam int CSR_INDEX_BITS   = 4;
   localparam int STEP_BITS        = 4;
   localparam int SRC1_POS         = 11;
   localparam int SRC2_POS         = 16;

   localparam logic [ACTION_BITS-1:0] ACT_QUERY    = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_APPEND   = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CONSUME  = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_REDIRECT = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_ALIGN    = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMMEDIATE_CODE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ADDRESS_CODE   = 4'd1;

   localparam logic [STEP_BITS-1:0] STEP_IDLE         = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_APPEND_PREP  = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_APPEND_SHIFT = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_APPEND_FIN   = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_CONSUME_PREP = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_SHIFT        = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_ALIGN_PREP   = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_REDIRECT     = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_EMIT         = 4'd8;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_APPEND_PREP,
      OP_SHIFT,
      OP_APPEND_FIN,
      OP_CONSUME_PREP,
      OP_ALIGN_PREP,
      OP_REDIRECT,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_DISPATCH,
      COND_LOOP,
      COND_EMIT
   } cond_type;

   typedef struct packed {
      op_type                 op;
      cond_type               cond;
      logic [STEP_BITS-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic                   cnt_zero;
      logic                   out_free;
      logic [STEP_BITS-1:0]   entry;
   } status_type;

   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type word;
      case (step)
         STEP_IDLE:         word = '{OP_LATCH,        COND_DISPATCH, STEP_IDLE};
         STEP_APPEND_PREP:  word = '{OP_APPEND_PREP,  COND_NEXT,     STEP_IDLE};
         STEP_APPEND_SHIFT: word = '{OP_SHIFT,        COND_LOOP,     STEP_APPEND_FIN};
         STEP_APPEND_FIN:   word = '{OP_APPEND_FIN,   COND_JUMP,     STEP_EMIT};
         STEP_CONSUME_PREP: word = '{OP_CONSUME_PREP, COND_NEXT,     STEP_IDLE};
         STEP_SHIFT:        word = '{OP_SHIFT,        COND_LOOP,     STEP_EMIT};
         STEP_ALIGN_PREP:   word = '{OP_ALIGN_PREP,   COND_JUMP,     STEP_SHIFT};
         STEP_REDIRECT:     word = '{OP_REDIRECT,     COND_JUMP,     STEP_EMIT};
         STEP_EMIT:         word = '{OP_EMIT,         COND_EMIT,     STEP_IDLE};
         default:           word = '{OP_NONE,         COND_JUMP,     STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ipab_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipab_req_if;
   import ipab_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ACTION_BITS-1:0]  action;
   logic [WINDOW_BITS-1:0]  window;
   logic [ADDR_BITS-1:0]    target_addr;
   logic [COUNT_BITS-1:0]   word_count;
   modport source (output valid, action, window, target_addr, word_count, input ready);
   modport sink (input valid, action, window, target_addr, word_count, output ready);
endinterface

interface ipab_rsp_if;
   import ipab_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [WINDOW_BITS-1:0]  head_window;
   logic                    addr_held;
   logic                    instr_complete;
   logic [ADDR_BITS-1:0]    start_addr;
   logic [COUNT_BITS-1:0]   words_held;
   logic                    error;
   modport source (output valid, head_window, addr_held, instr_complete, start_addr,
                   words_held, error, input ready);
   modport sink (input valid, head_window, addr_held, instr_complete, start_addr,
                 words_held, error, output ready);
endinterface

interface ipab_csr_if;
   import ipab_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_BITS-1:0]  index;
   logic [CODE_BITS-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ipab_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module ipab_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ipab_pkg::status_type status,
   output ipab_pkg::op_type         op_exec
);
   import ipab_pkg::*;

   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   ucode_type            word;

   assign word = ucode_rom(step_ff);

   always_comb begin
      step_in   = step_ff;
      op_exec   = OP_NONE;
      req_ready = 1'b0;
      case (word.cond)
         COND_NEXT: begin
            op_exec = word.op;
            step_in = step_ff + 4'd1;
         end
         COND_JUMP: begin
            op_exec = word.op;
            step_in = word.target;
         end
         COND_DISPATCH: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_exec = word.op;
               step_in = status.entry;
            end
         end
         COND_LOOP: begin
            if (status.cnt_zero) begin
               step_in = word.target;
            end else begin
               op_exec = word.op;
            end
         end
         COND_EMIT: begin
            if (status.out_free) begin
               op_exec = word.op;
               step_in = word.target;
            end
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ipab_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "instruction_prefetch_align_buffer_top_assert.svh"

module ipab_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ipab_pkg::op_type                     op_exec,
   output ipab_pkg::status_type                      status,
   input  wire logic [ipab_pkg::ACTION_BITS-1:0]     req_action,
   input  wire logic [ipab_pkg::WINDOW_BITS-1:0]     req_window,
   input  wire logic [ipab_pkg::ADDR_BITS-1:0]       req_target_addr,
   input  wire logic [ipab_pkg::COUNT_BITS-1:0]      req_word_count,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [ipab_pkg::WINDOW_BITS-1:0]          rsp_head_window,
   output logic                                      rsp_addr_held,
   output logic                                      rsp_instr_complete,
   output logic [ipab_pkg::ADDR_BITS-1:0]            rsp_start_addr,
   output logic [ipab_pkg::COUNT_BITS-1:0]           rsp_words_held,
   output logic                                      rsp_error,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ipab_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ipab_pkg::CODE_BITS-1:0]       csr_data
);
   import ipab_pkg::*;

   logic [WINDOW_BITS-1:0] store0_ff, store0_in;
   logic [WINDOW_BITS-1:0] store1_ff, store1_in;
   logic [ADDR_BITS-1:0]   head_ff, head_in;
   logic [COUNT_BITS-1:0]  valid_ff, valid_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CODE_BITS-1:0]   imm_code_ff;
   logic [CODE_BITS-1:0]   adr_code_ff;

   logic [ACTION_BITS-1:0] act_ff;
   logic [WINDOW_BITS-1:0] win_ff;
   logic [ADDR_BITS-1:0]   target_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [3:0]             off_ff;
   logic                   held_ff;
   logic                   err_ff;

   logic                   rsp_valid_ff;
   logic [WINDOW_BITS-1:0] rsp_window_ff;
   logic                   rsp_held_ff;
   logic                   rsp_complete_ff;
   logic [ADDR_BITS-1:0]   rsp_addr_ff;
   logic [COUNT_BITS-1:0]  rsp_words_ff;
   logic                   rsp_error_ff;

   logic [ADDR_BITS-1:0]   offset;
   logic [ADDR_BITS-1:0]   limit;
   logic                   held;
   logic                   err;
   logic [STEP_BITS-1:0]   entry;
   logic [COUNT_BITS-1:0]  align_words;
   logic [CODE_BITS-1:0]   src1;
   logic [CODE_BITS-1:0]   src2;
   logic [1:0]             need;
   logic                   complete;

   assign offset = req_target_addr - head_ff;
   assign limit  = ADDR_BITS'({valid_ff - 4'd1, 1'b0});
   assign held   = (valid_ff != '0) && (offset <= limit);
   assign err    = ((req_action == ACT_APPEND) &&
                    (valid_ff >= COUNT_BITS'(WORDS_PER_WINDOW))) ||
                   ((req_action == ACT_ALIGN) && (!held || offset[0]));

   always_comb begin
      case (req_action)
         ACT_APPEND:   entry = err ? STEP_EMIT : STEP_APPEND_PREP;
         ACT_CONSUME:  entry = STEP_CONSUME_PREP;
         ACT_REDIRECT: entry = STEP_REDIRECT;
         ACT_ALIGN:    entry = err ? STEP_EMIT : STEP_ALIGN_PREP;
         default:      entry = STEP_EMIT;
      endcase
   end

   assign src1     = store0_ff[WINDOW_BITS-SRC1_POS +: CODE_BITS];
   assign src2     = store0_ff[WINDOW_BITS-SRC2_POS +: CODE_BITS];
   assign need     = 2'd1 + {1'b0, (src1 == imm_code_ff) || (src1 == adr_code_ff)}
                          + {1'b0, (src2 == imm_code_ff) || (src2 == adr_code_ff)};
   assign complete = valid_ff >= COUNT_BITS'(need);

   assign align_words = {1'b0, off_ff[3:1]};

   assign status.cnt_zero = (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.entry    = entry;

   always_comb begin
      store0_in = store0_ff;
      store1_in = store1_ff;
      head_in   = head_ff;
      valid_in  = valid_ff;
      cnt_in    = cnt_ff;
      case (op_exec)
         OP_APPEND_PREP: begin
            case (valid_ff[1:0])
               2'd1:    store0_in = store0_ff >> (3 * WORD_BITS);
               2'd2:    store0_in = store0_ff >> (2 * WORD_BITS);
               2'd3:    store0_in = store0_ff >> WORD_BITS;
               default: store0_in = '0;
            endcase
            store1_in = win_ff;
            cnt_in    = COUNT_BITS'(WORDS_PER_WINDOW) - valid_ff;
         end
         OP_SHIFT: begin
            store0_in = {store0_ff[WINDOW_BITS-WORD_BITS-1:0],
                         store1_ff[WINDOW_BITS-1 -: WORD_BITS]};
            store1_in = {store1_ff[WINDOW_BITS-WORD_BITS-1:0], {WORD_BITS{1'b0}}};
            cnt_in    = cnt_ff - 4'd1;
         end
         OP_APPEND_FIN: begin
            valid_in = valid_ff + COUNT_BITS'(WORDS_PER_WINDOW);
         end
         OP_CONSUME_PREP: begin
            head_in  = head_ff + ADDR_BITS'({count_ff, 1'b0});
            valid_in = (valid_ff > count_ff) ? (valid_ff - count_ff) : '0;
            cnt_in   = count_ff;
         end
         OP_ALIGN_PREP: begin
            head_in  = target_ff;
            valid_in = valid_ff - align_words;
            cnt_in   = align_words;
         end
         OP_REDIRECT: begin
            store0_in = win_ff;
            store1_in = '0;
            head_in   = target_ff;
            valid_in  = COUNT_BITS'(WORDS_PER_WINDOW);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store0_ff    <= '0;
         store1_ff    <= '0;
         head_ff      <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         imm_code_ff  <= 5'd0;
         adr_code_ff  <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         store0_ff <= store0_in;
         store1_ff <= store1_in;
         head_ff   <= head_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
         if (csr_valid && (csr_index == CSR_IMMEDIATE_CODE)) begin
            imm_code_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_ADDRESS_CODE)) begin
            adr_code_ff <= csr_data;
         end
         if (op_exec == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_exec == OP_LATCH) begin
         act_ff    <= req_action;
         win_ff    <= req_window;
         target_ff <= req_target_addr;
         count_ff  <= req_word_count;
         off_ff    <= offset[3:0];
         held_ff   <= held;
         err_ff    <= err;
      end
      if (op_exec == OP_EMIT) begin
         rsp_window_ff   <= store0_ff;
         rsp_held_ff     <= held_ff;
         rsp_complete_ff <= complete;
         rsp_addr_ff     <= head_ff;
         rsp_words_ff    <= valid_ff;
         rsp_error_ff    <= err_ff;
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_head_window    = rsp_window_ff;
   assign rsp_addr_held      = rsp_held_ff;
   assign rsp_instr_complete = rsp_complete_ff;
   assign rsp_start_addr     = rsp_addr_ff;
   assign rsp_words_held     = rsp_words_ff;
   assign rsp_error          = rsp_error_ff;

   `IPAB_ASSERT(a_words_bounded, clock, reset, valid_ff <= 4'd8, "word count above capacity")
   `IPAB_ASSERT(a_loop_done_at_emit, clock, reset, (op_exec == OP_EMIT) |-> (cnt_ff == '0), "shift loop not finished at result")
   `IPAB_ASSERT(a_error_source, clock, reset, ((op_exec == OP_EMIT) && err_ff) |-> ((act_ff == ACT_APPEND) || (act_ff == ACT_ALIGN)), "error flagged for an action that cannot fail")
   `IPAB_ASSERT(a_append_fill, clock, reset, (op_exec == OP_APPEND_FIN) |=> (valid_ff >= 4'd4), "append left fewer words than a window")

endmodule

`default_nettype wire

FILE: hdl/instruction_prefetch_align_buffer_top.sv
// Instruction alignment buffer between fetch and decode.
// Requests arrive on req_bus (valid/ready): an action with a fetched window, a target
// address and a consumed word count. Each request yields exactly one response on rsp_bus
// with the head window, head address, word count, hit flag, completeness and error flag.
// csr_bus writes the immediate and address operand codes; it is always ready.
// A small microcode program steps a shared one-word shifter, so requests are handled
// one at a time. Query, error and unknown-action requests go straight to the result
// step; redirect loads the window and head address first; consume and align first
// move the head and the word count, then shift the buffer word by word; append
// places the old words and the new window, shifts the window in, then adds a window
// to the word count. The shifter moves one word per cycle.
// A finished response sits in an output register; a new request is accepted while it
// waits. When the receiver stalls, the next response waits in its final step, and
// no further request is taken until it can be stored.
// Reset is synchronous and clears the buffer, the head address, the word count and
// the operand codes to their defaults (immediate code 0, address code 1).
`timescale 1ns / 1ps
`default_nettype none

module instruction_prefetch_align_buffer_top (
   input  wire logic  clock,
   input  wire logic  reset,
   ipab_req_if.sink   req_bus,
   ipab_rsp_if.source rsp_bus,
   ipab_csr_if.sink   csr_bus
);
   import ipab_pkg::*;

   status_type status;
   op_type     op_exec;

   ipab_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .op_exec   (op_exec)
   );

   ipab_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .op_exec            (op_exec),
      .status             (status),
      .req_action         (req_bus.action),
      .req_window         (req_bus.window),
      .req_target_addr    (req_bus.target_addr),
      .req_word_count     (req_bus.word_count),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_head_window    (rsp_bus.head_window),
      .rsp_addr_held      (rsp_bus.addr_held),
      .rsp_instr_complete (rsp_bus.instr_complete),
      .rsp_start_addr     (rsp_bus.start_addr),
      .rsp_words_held     (rsp_bus.words_held),
      .rsp_error          (rsp_bus.error),
      .csr_valid          (csr_bus.valid),
      .csr_ready          (csr_bus.ready),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data)
   );

endmodule

`default_nettype wire
